FILE: design/packet_dedup_table_top_defines.svh
// Assertion macros for the packet dedup table.
`ifndef PACKET_DEDUP_TABLE_TOP_DEFINES_SVH
`define PACKET_DEDUP_TABLE_TOP_DEFINES_SVH

// ante |-> cons, checked on every clock edge outside reset
`define PDT_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("packet dedup table check failed");

// ante |=> cons, checked on every clock edge outside reset
`define PDT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("packet dedup table check failed");

`endif

FILE: design/pdt_pkg.sv
package pdt_pkg;

	localparam int PDT_SLOTS_DEF = 8;
	localparam logic [7:0] COUNT_MAX = 8'hFF;
	localparam int IN_TDATA_W = 200;
	localparam int OUT_TDATA_W = 216;

	typedef struct packed {
		logic [31:0] strength_low;
		logic [7:0]  strength_high;
		logic [4:0]  channel;
		logic [63:0] other_bits;
		logic [63:0] payload;
		logic [7:0]  flags;
		logic [15:0] key;
	} rec_t;

	typedef struct packed {
		logic [7:0] zigzag_cnt;
		logic [7:0] crc_cnt;
		rec_t       rec;
	} entry_t;

	typedef struct packed {
		logic check;
		logic append;
	} look_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_DRAIN
	} state_t;

endpackage

FILE: design/pdt_cell.sv
module pdt_cell
	import pdt_pkg::*;
(
	input  logic   clk,
	input  logic   shift_en,
	input  entry_t d,
	output entry_t q
);

	entry_t entry_q;

	always_ff @(posedge clk) begin
		if (shift_en) begin
			entry_q <= d;
		end
	end

	assign q = entry_q;

endmodule

FILE: design/pdt_head.sv
module pdt_head
	import pdt_pkg::*;
(
	input  entry_t cur,
	input  rec_t   item,
	input  logic   zigzag,
	input  look_t  look,
	output entry_t nxt,
	output logic   taken
);

	logic match;
	logic hit;
	logic stronger;

	always_comb begin
		match    = (cur.rec.key == item.key) && (cur.rec.flags == item.flags);
		hit      = look.check && match;
		stronger = {item.strength_high, item.strength_low} >
			{cur.rec.strength_high, cur.rec.strength_low};
		taken    = hit || look.append;
		nxt      = cur;
		if (look.append) begin
			nxt.rec        = item;
			nxt.crc_cnt    = zigzag ? 8'd0 : 8'd1;
			nxt.zigzag_cnt = zigzag ? 8'd1 : 8'd0;
		end else if (hit) begin
			if (stronger) begin
				nxt.rec = item;
			end
			if (zigzag) begin
				if (cur.zigzag_cnt != COUNT_MAX) begin
					nxt.zigzag_cnt = cur.zigzag_cnt + 8'd1;
				end
			end else begin
				if (cur.crc_cnt != COUNT_MAX) begin
					nxt.crc_cnt = cur.crc_cnt + 8'd1;
				end
			end
		end
	end

endmodule

FILE: design/packet_dedup_table_top.sv
// Packet dedup table.
// Input stream (s_*): one transfer per item. s_tuser[0] selects the action
// (0 = received packet, 1 = drain), s_tuser[1] marks a zigzag copy.
// Output stream (m_*): drain results only. m_tuser[0] = entry valid,
// m_tlast marks the final result of a drain.
// Entries sit in a ring of TABLE_SLOTS cells that rotates one slot per cycle
// past a single compare/update head while a search or a drain is shifting.
// A received packet is searched over one full rotation of the ring before
// the next transfer is accepted; on a full table it is dropped without a search.
// A drain of n entries gives n results via the DRAIN state and output register,
// one result per cycle unless the output stalls; an empty table gives one invalid result.
// One item is in flight at a time; s_tready is high only while idle.
// When a result is held and m_tready is low, the drain rotation pauses and the
// output register holds its result.
// Reset empties the table and clears the output valid flag.
module packet_dedup_table_top
	import pdt_pkg::*;
#(
	parameter int TABLE_SLOTS = PDT_SLOTS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// key, flags, payload, other bits, channel, strength high, strength low, pad
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	// action, zigzag_copy
	input  logic [1:0]             s_tuser,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// key, flags, payload, other bits, channel, strength high, strength low,
	// crc copies, zigzag copies, pad
	output logic [OUT_TDATA_W-1:0] m_tdata,
	// entry_valid
	output logic [0:0]             m_tuser,
	output logic                   m_tlast
);

`include "packet_dedup_table_top_defines.svh"

	localparam int CW = $clog2(TABLE_SLOTS);
	localparam logic [CW-1:0] LAST_SLOT = CW'(TABLE_SLOTS - 1);

	state_t        state_q, state_d;
	logic [CW-1:0] count_q;
	logic [CW-1:0] step_q;
	logic          found_q;
	rec_t          item_q;
	logic          zigzag_q;

	entry_t        cell_q [TABLE_SLOTS];
	entry_t        cell_d [TABLE_SLOTS];
	entry_t        head_nxt;
	logic          head_taken;
	look_t         look;
	logic          shift_en;
	logic          can_emit;
	logic          emit;
	logic          in_xfer;

	entry_t        out_q;
	logic          out_valid_q;
	logic          out_entry_q;
	logic          out_last_q;

	assign in_xfer  = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign can_emit = !out_valid_q || m_tready;

	always_comb begin
		look.check  = (step_q < count_q) && !found_q;
		look.append = (step_q == count_q) && !found_q;
	end

	pdt_head u_head (
		.cur    (cell_q[0]),
		.item   (item_q),
		.zigzag (zigzag_q),
		.look   (look),
		.nxt    (head_nxt),
		.taken  (head_taken)
	);

	for (genvar i = 0; i < TABLE_SLOTS; i++) begin : g_cell
		if (i == TABLE_SLOTS - 1) begin : g_tail
			assign cell_d[i] = (state_q == ST_SEARCH) ? head_nxt : cell_q[0];
		end else begin : g_body
			assign cell_d[i] = cell_q[i+1];
		end
		pdt_cell u_cell (
			.clk      (clk),
			.shift_en (shift_en),
			.d        (cell_d[i]),
			.q        (cell_q[i])
		);
	end

	always_comb begin
		state_d  = state_q;
		shift_en = 1'b0;
		emit     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					if (s_tuser[0]) begin
						state_d = ST_DRAIN;
					end else if (count_q < LAST_SLOT) begin
						state_d = ST_SEARCH;
					end
				end
			end
			ST_SEARCH: begin
				shift_en = 1'b1;
				if (step_q == LAST_SLOT) begin
					state_d = ST_IDLE;
				end
			end
			ST_DRAIN: begin
				if (can_emit) begin
					emit     = 1'b1;
					shift_en = (count_q != '0);
					if (count_q == '0 || step_q == count_q - CW'(1)) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			step_q      <= '0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_xfer) begin
				step_q  <= '0;
				found_q <= 1'b0;
			end else if (shift_en) begin
				step_q <= step_q + CW'(1);
			end
			if (state_q == ST_SEARCH && head_taken) begin
				found_q <= 1'b1;
				if (look.append) begin
					count_q <= count_q + CW'(1);
				end
			end
			if (emit && state_d == ST_IDLE) begin
				count_q <= '0;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			item_q.key           <= s_tdata[15:0];
			item_q.flags         <= s_tdata[23:16];
			item_q.payload       <= s_tdata[87:24];
			item_q.other_bits    <= s_tdata[151:88];
			item_q.channel       <= s_tdata[156:152];
			item_q.strength_high <= s_tdata[164:157];
			item_q.strength_low  <= s_tdata[196:165];
			zigzag_q             <= s_tuser[1];
		end
		if (emit) begin
			out_q       <= (count_q == '0) ? '0 : cell_q[0];
			out_entry_q <= (count_q != '0);
			out_last_q  <= (count_q == '0) || (step_q == count_q - CW'(1));
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_entry_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {3'b000, out_q.zigzag_cnt, out_q.crc_cnt,
		out_q.rec.strength_low, out_q.rec.strength_high, out_q.rec.channel,
		out_q.rec.other_bits, out_q.rec.payload, out_q.rec.flags, out_q.rec.key};

	`PDT_ASSERT_NOW(a_count_range, 1'b1, count_q <= LAST_SLOT)
	`PDT_ASSERT_NOW(a_search_resolves, state_q == ST_SEARCH && step_q == LAST_SLOT,
		found_q || head_taken)
	`PDT_ASSERT_NOW(a_invalid_is_last, m_tvalid && !m_tuser[0], m_tlast)
	`PDT_ASSERT_NEXT(a_search_grows_by_one, state_q == ST_SEARCH,
		count_q == $past(count_q) || count_q == $past(count_q) + CW'(1))

endmodule
